>>> design/debounced_pin_and_timer_table_core_macros.svh
// Assertion macros for the timer table core
`ifndef DEBOUNCED_PIN_AND_TIMER_TABLE_CORE_MACROS_SVH
`define DEBOUNCED_PIN_AND_TIMER_TABLE_CORE_MACROS_SVH
// Assert an implication that holds in the next cycle
`define DPT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
// Assert an implication in the same cycle
`define DPT_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`endif

>>> design/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg
// Types and constants shared by the timer table core.
// ----------------------------------------------------------------------------
`default_nettype none
package dpt_pkg;
    localparam int TABLE_ENTRIES = 8;
    localparam int PIN_COUNT     = 14;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_SCHED  = 3'd1;
    localparam logic [2:0] ACT_CHECK  = 3'd2;
    localparam logic [2:0] ACT_QUERY  = 3'd3;
    localparam logic [2:0] ACT_COUNTS = 3'd4;

    localparam logic [1:0] REG_RISE = 2'd0;
    localparam logic [1:0] REG_FALL = 2'd1;
    localparam logic [1:0] REG_TOP  = 2'd2;

    localparam logic [1:0] QK_HIGH = 2'd0;

    typedef struct packed {
        logic [2:0]  action;
        logic signed [7:0] ident;
        logic        recurring;
        logic [31:0] period_ms;
        logic [13:0] pin_levels;
        logic [1:0]  query_kind;
        logic        count_direction;
        logic        count_reset;
    } cmd_t;

    typedef struct packed {
        logic        found;
        logic [15:0] reply_value;
    } rsp_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic [7:0]  ident;
        logic        active;
        logic        recurring;
        logic [31:0] due;
        logic [31:0] period;
        logic [4:0]  counter;
        logic        level;
        logic        change;
        logic [15:0] rise_cnt;
        logic [15:0] fall_cnt;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_MODIFY,
        ST_TICK_RD,
        ST_TICK_WAIT,
        ST_TICK_WR
    } state_t;

    typedef struct packed {
        logic [4:0] rise_th;
        logic [4:0] fall_th;
        logic [4:0] top;
    } thr_t;

    function automatic logic is_pin(input logic [7:0] id);
        return (id[7] == 1'b0) && (int'(id) < PIN_COUNT);
    endfunction
endpackage
`default_nettype wire

>>> design/dpt_check.sv
// ----------------------------------------------------------------------------
// dpt_check
// Timer expiry and debounce step for one entry (combinational).
// ----------------------------------------------------------------------------
`default_nettype none
module dpt_check (
    input  dpt_pkg::entry_t  ent,
    input  logic [31:0]      now,
    input  logic [13:0]      levels,
    input  dpt_pkg::thr_t    thr,
    output dpt_pkg::entry_t  upd,
    output logic             expired
);
    import dpt_pkg::*;

    logic       raw;
    logic       integ;
    logic [5:0] c;

    always_comb
    begin
        upd     = ent;
        expired = ent.active && (ent.due <= now);
        integ   = 1'b1;
        raw     = 1'b0;
        c       = 6'd0;
        if (expired)
        begin
            // reload or retire the timer
            if (ent.recurring)
            begin
                upd.due = ent.due + ent.period + {31'd0, ent.period == 32'd0};
                integ   = (ent.period != 32'd0);
            end
            else
            begin
                upd.active = 1'b0;
            end
            // step the integrator
            if (is_pin(ent.ident))
            begin
                raw = levels[ent.ident[3:0]];
                if (raw)
                begin
                    c = integ ? {1'b0, ent.counter} + 6'd1 : {1'b0, thr.top};
                    if (c > {1'b0, thr.rise_th})
                    begin
                        c = {1'b0, thr.top};
                        if (!ent.level)
                        begin
                            upd.change   = 1'b1;
                            upd.rise_cnt = ent.rise_cnt + 16'd1;
                        end
                        upd.level = 1'b1;
                    end
                end
                else
                begin
                    c = integ ? {1'b0, ent.counter} - 6'd1 : 6'd0;
                    if (c[5] || (c < {1'b0, thr.fall_th}))
                    begin
                        c = 6'd0;
                        if (ent.level)
                        begin
                            upd.change   = 1'b1;
                            upd.fall_cnt = ent.fall_cnt + 16'd1;
                        end
                        upd.level = 1'b0;
                    end
                end
                upd.counter = c[4:0];
            end
        end
    end
endmodule
`default_nettype wire

>>> design/debounced_pin_and_timer_table_core.sv
// ----------------------------------------------------------------------------
// debounced_pin_and_timer_table_core
// Timer table with per-pin integrating debouncers, state held in one memory.
// ----------------------------------------------------------------------------
// Channel | Ports                      | Handshake
// command | cmd                        | start high while busy low
// result  | rsp                        | rsp_valid, one cycle, no stall
// config  | cfg_we, cfg_index, cfg_data | write at cfg_we
// A lookup scans one identifier a cycle for each stored entry, then issues the
// memory read, then waits and does the modify/write; an unused action code
// goes from the scan straight to the modify/write step without a read.
// A tick walks each entry through a read, a wait and a write step, then ends
// with a closing step that gives the result.
// The result word is on the ports in the first cycle after busy falls.
// Reset clears count and time; entries beyond the count are never used.
// The result strobe cannot be stalled.
`default_nettype none
`include "debounced_pin_and_timer_table_core_macros.svh"
module debounced_pin_and_timer_table_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  dpt_pkg::cmd_t cmd,
    output logic          rsp_valid,
    output dpt_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [4:0]    cfg_data
);
    import dpt_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    logic [7:0] id_reg [TABLE_ENTRIES];

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    thr_t   thr_reg;
    logic [31:0] now_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    logic hit_ok_reg, hit_ok_next;
    entry_t rd_reg;
    logic   rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic   wr_en;
    entry_t wr_data;
    logic   rsp_valid_next;
    rsp_t   rsp_next;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg;
    logic   append;
    entry_t upd;
    logic   expired;
    logic   hi;

    dpt_check u_check (
        .ent(rd_reg), .now(now_reg), .levels(cmd_reg.pin_levels),
        .thr(thr_reg), .upd(upd), .expired(expired)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = (cmd.action == ACT_TICK) ? ST_TICK_RD : ST_SCAN;
            ST_SCAN:
                if (cmd_reg.action > ACT_COUNTS)
                    state_next = ST_MODIFY;
                else if (ptr_reg >= count_reg)
                    state_next = ST_WAIT;
            ST_WAIT:      state_next = ST_MODIFY;
            ST_MODIFY:    state_next = ST_IDLE;
            ST_TICK_RD:   state_next = (ptr_reg >= count_reg) ? ST_IDLE : ST_TICK_WAIT;
            ST_TICK_WAIT: state_next = ST_TICK_WR;
            ST_TICK_WR:   state_next = ST_TICK_RD;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ptr_next       = ptr_reg;
        hit_next       = hit_reg;
        hit_ok_next    = hit_ok_reg;
        rd_en          = 1'b0;
        rd_addr        = hit_reg;
        wr_en          = 1'b0;
        wr_data        = rd_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = '0;
        append         = 1'b0;
        hi             = cmd_reg.pin_levels[cmd_reg.ident[3:0]] && is_pin(cmd_reg.ident);
        case (state_reg)
            ST_IDLE:
            begin
                ptr_next    = '0;
                hit_ok_next = 1'b0;
            end
            ST_SCAN:
            begin
                // scan identifiers, last match wins
                if (ptr_reg < count_reg)
                begin
                    if (id_reg[ptr_reg[IDX_W-1:0]] == cmd_reg.ident)
                    begin
                        hit_next    = ptr_reg[IDX_W-1:0];
                        hit_ok_next = 1'b1;
                    end
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = hit_reg;
                end
            end
            ST_MODIFY:
            begin
                rsp_valid_next = 1'b1;
                case (cmd_reg.action)
                    ACT_SCHED:
                    begin
                        if (hit_ok_reg || (count_reg < CNT_W'(TABLE_ENTRIES)))
                        begin
                            append            = !hit_ok_reg;
                            wr_en             = 1'b1;
                            // a fresh entry starts from its reset contents
                            wr_data           = hit_ok_reg ? rd_reg : '0;
                            wr_data.ident     = cmd_reg.ident;
                            wr_data.due       = cmd_reg.period_ms + now_reg;
                            wr_data.period    = cmd_reg.period_ms;
                            wr_data.recurring = cmd_reg.recurring;
                            wr_data.rise_cnt  = '0;
                            wr_data.fall_cnt  = '0;
                            wr_data.active    = cmd_reg.recurring ||
                                                (cmd_reg.period_ms != 32'd0);
                            if (is_pin(cmd_reg.ident))
                            begin
                                wr_data.counter = hi ? thr_reg.top : 5'd0;
                                wr_data.change  = 1'b0;
                                wr_data.level   = hi;
                            end
                            rsp_next.found = 1'b1;
                        end
                    end
                    ACT_CHECK:
                    begin
                        if (hit_ok_reg)
                        begin
                            wr_en                = 1'b1;
                            wr_data              = upd;
                            rsp_next.found       = 1'b1;
                            rsp_next.reply_value = {15'd0, expired};
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (hit_ok_reg)
                        begin
                            rsp_next.found = 1'b1;
                            if (rd_reg.active)
                            begin
                                wr_en          = 1'b1;
                                wr_data.change = 1'b0;
                                if (cmd_reg.query_kind[1])
                                    rsp_next.reply_value = {15'd0, rd_reg.level};
                                else
                                    rsp_next.reply_value = {15'd0, rd_reg.change &&
                                        (rd_reg.level == (cmd_reg.query_kind == QK_HIGH))};
                            end
                        end
                    end
                    ACT_COUNTS:
                    begin
                        if (hit_ok_reg)
                        begin
                            rsp_next.found       = 1'b1;
                            rsp_next.reply_value = cmd_reg.count_direction ?
                                                   rd_reg.rise_cnt : rd_reg.fall_cnt;
                            if (cmd_reg.count_reset)
                            begin
                                wr_en            = 1'b1;
                                wr_data.rise_cnt = '0;
                                wr_data.fall_cnt = '0;
                            end
                        end
                    end
                    default: ;
                endcase
                if (append)
                    rd_addr = count_reg[IDX_W-1:0];
            end
            ST_TICK_RD:
            begin
                if (ptr_reg >= count_reg)
                    rsp_valid_next = 1'b1;
                else if (is_pin(id_reg[ptr_reg[IDX_W-1:0]]))
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg[IDX_W-1:0];
                end
            end
            ST_TICK_WR:
            begin
                rd_addr  = ptr_reg[IDX_W-1:0];
                wr_en    = is_pin(id_reg[ptr_reg[IDX_W-1:0]]);
                wr_data  = upd;
                ptr_next = ptr_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            hit_reg       <= '0;
            hit_ok_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            thr_reg       <= '{rise_th: 5'd15, fall_th: 5'd5, top: 5'd20};
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            hit_reg       <= hit_next;
            hit_ok_reg    <= hit_ok_next;
            rsp_valid_reg <= rsp_valid_next;
            if (state_reg == ST_IDLE && start && cmd.action == ACT_TICK)
                now_reg <= now_reg + 32'd1;
            if (append)
                count_reg <= count_reg + 1'b1;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RISE: thr_reg.rise_th <= cfg_data;
                    REG_FALL: thr_reg.fall_th <= cfg_data;
                    REG_TOP:  thr_reg.top     <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // hold the command word and result word
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            cmd_reg <= cmd;
        rsp_reg <= rsp_next;
    end

    // entry memory: one read, one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[rd_addr]    <= wr_data;
            id_reg[rd_addr] <= wr_data.ident;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `DPT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `DPT_ASSERT_NOW(a_count_max, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_ENTRIES))
    `DPT_ASSERT_NEXT(a_done_idle, clk, rst_n, rsp_valid_next, !busy)
endmodule
`default_nettype wire
